@@ hw/rtl/cdg_pkg.sv @@
// Package for the central-difference gradient block: widths, pixel and
// gradient types, register indexes and the pipeline stage record.
// No dependencies; every other file of the block depends on it.
package cdg_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int ROW_BITS    = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int PEND_BITS   = COL_BITS + 1;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    // Register index, taken from paddr bit 2.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Input item kinds.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef logic signed [PIXEL_BITS-1:0] t_pixel;
    typedef logic signed [PIXEL_BITS:0]   t_grad;
    typedef logic [COL_BITS-1:0]          t_col;
    typedef logic [ROW_BITS-1:0]          t_row;

    // Item held in the stage that waits for the line-buffer read data.
    typedef struct packed {
        logic   valid;
        logic   is_pixel;
        logic   emit;
        logic   border;
        logic   last;
        t_row   row;
        t_col   col;
        t_col   addr;
        t_pixel pixel;
    } t_s1;

    function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] r;
        r = w;
        if (w < WIDTH_BITS'(2)) r = WIDTH_BITS'(2);
        else if (w > WIDTH_BITS'(MAX_WIDTH)) r = WIDTH_BITS'(MAX_WIDTH);
        return r;
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] h);
        logic [HEIGHT_BITS-1:0] r;
        r = h;
        if (h < HEIGHT_BITS'(2)) r = HEIGHT_BITS'(2);
        else if (h > HEIGHT_BITS'(MAX_HEIGHT)) r = HEIGHT_BITS'(MAX_HEIGHT);
        return r;
    endfunction

endpackage

@@ hw/rtl/cdg_if.sv @@
// Request channel interfaces of the central-difference gradient block:
// the input channel (pixel or drain requests) and the result channel.
// Depends on cdg_pkg for the payload types.
interface cdg_in_if;
    logic            valid;
    logic            ready;
    logic            action;
    cdg_pkg::t_pixel pixel;

    modport source (output valid, output action, output pixel, input ready);
    modport sink   (input valid, input action, input pixel, output ready);
endinterface

interface cdg_out_if;
    logic           valid;
    logic           ready;
    cdg_pkg::t_grad grad_vert;
    cdg_pkg::t_grad grad_horiz;
    cdg_pkg::t_row  out_row;
    cdg_pkg::t_col  out_col;
    logic           frame_end;

    modport source (output valid, output grad_vert, output grad_horiz, output out_row,
                    output out_col, output frame_end, input ready);
    modport sink   (input valid, input grad_vert, input grad_horiz, input out_row,
                    input out_col, input frame_end, output ready);
endinterface

@@ hw/rtl/central_difference_gradient.sv @@
// Central-difference gradient over a raster pixel stream. One request is taken
// per clock when the result side keeps up; a pixel request reads both line
// buffers (two RAMs of MAX_WIDTH entries, one read and one write each per
// cycle) and its result, if any, goes from the RAM-data stage to the output
// register, in raster order image_width+1 pixel requests behind the input.
// Gradients are in half-LSB units and zero on the border. After the last pixel
// of a frame, send one drain request per pending result; the result with
// frame_end set closes the frame. Register writes abort the frame in progress.
// Depends on cdg_pkg and cdg_if.
module central_difference_gradient (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cdg_in_if.sink                       i_in,
    cdg_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdg_pkg::APB_AW-1:0]   paddr,
    input  logic [cdg_pkg::APB_DW-1:0]   pwdata,
    output logic [cdg_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import cdg_pkg::*;

    // Configuration.
    logic [WIDTH_BITS-1:0]  r_width, r_width_eff;
    logic [HEIGHT_BITS-1:0] r_height, r_height_eff;
    logic                   cfg_wr;

    // Frame counters.
    t_col                 r_in_col, n_in_col;
    t_row                 r_in_row, n_in_row;
    logic                 r_in_done, n_in_done;
    logic [PEND_BITS-1:0] r_pending, n_pending;
    t_row                 r_res_row, n_res_row;
    t_col                 r_res_col, n_res_col;

    // Line buffers and window.
    t_pixel r_older_mem [MAX_WIDTH];
    t_pixel r_newer_mem [MAX_WIDTH];
    t_pixel r_top, r_mid;
    t_pixel r_recent0, r_recent1, r_recent2, r_above_prev;

    t_s1 r_s1, n_s1;

    logic r_out_valid;
    t_grad r_out_gv, r_out_gh;
    t_row  r_out_row;
    t_col  r_out_col;
    logic  r_out_last;

    logic in_acc, proc_pix, drain_emit, s1_adv, s1_load;
    t_col c_addr;
    logic [WIDTH_BITS:0]  col_inc;
    logic [HEIGHT_BITS:0] row_inc;
    logic [WIDTH_BITS:0]  res_col_inc;
    logic                 pix_emit, emit, border, last;
    t_grad gv, gh;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_width_eff  <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_height_eff <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width     <= pwdata[WIDTH_BITS-1:0];
                r_width_eff <= eff_width(pwdata[WIDTH_BITS-1:0]);
            end else begin
                r_height     <= pwdata[HEIGHT_BITS-1:0];
                r_height_eff <= eff_height(pwdata[HEIGHT_BITS-1:0]);
            end
        end
    end

    // Handshake: the stage waiting for RAM data moves on unless it carries a
    // result and the output register is full and not being taken.
    assign s1_adv  = r_s1.valid && (!r_s1.emit || !r_out_valid || o_out.ready);
    assign s1_load = s1_adv && r_s1.emit;
    assign i_in.ready = !r_s1.valid || s1_adv;
    assign in_acc  = i_in.valid && i_in.ready;

    assign proc_pix   = (i_in.action == ACT_PIXEL) && !r_in_done;
    assign drain_emit = (i_in.action == ACT_DRAIN) && r_in_done && (r_pending != '0);

    // Request control: counters advance at acceptance, independent of RAM data.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_pending = r_pending;
        n_res_row = r_res_row;
        n_res_col = r_res_col;

        c_addr = ({1'b0, r_in_col} >= r_width_eff) ? COL_BITS'(r_width_eff - 1'b1) : r_in_col;
        col_inc = {2'b00, c_addr} + 1'b1;
        row_inc = {2'b00, r_in_row} + 1'b1;
        pix_emit = ({1'b0, r_pending} + 1'b1) > ({1'b0, r_width_eff} + 1'b1);
        emit = proc_pix ? pix_emit : drain_emit;
        border = (r_res_row == '0) || ({1'b0, r_res_row} >= r_height_eff - 1'b1) ||
                 (r_res_col == '0) || ({1'b0, r_res_col} >= r_width_eff - 1'b1);
        last   = ({1'b0, r_res_row} >= r_height_eff - 1'b1) &&
                 ({1'b0, r_res_col} >= r_width_eff - 1'b1);
        res_col_inc = {2'b00, r_res_col} + 1'b1;

        if (proc_pix) begin
            n_pending = r_pending + 1'b1;
            if (col_inc >= {1'b0, r_width_eff}) begin
                n_in_col = '0;
                n_in_row = row_inc[ROW_BITS-1:0];
                if (row_inc >= {1'b0, r_height_eff}) n_in_done = 1'b1;
            end else begin
                n_in_col = col_inc[COL_BITS-1:0];
            end
        end

        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_in_done = 1'b0;
                n_pending = '0;
                n_res_row = '0;
                n_res_col = '0;
            end else begin
                n_pending = n_pending - 1'b1;
                if (res_col_inc >= {1'b0, r_width_eff}) begin
                    n_res_col = '0;
                    n_res_row = r_res_row + 1'b1;
                end else begin
                    n_res_col = res_col_inc[COL_BITS-1:0];
                end
            end
        end

        n_s1.valid    = proc_pix || drain_emit;
        n_s1.is_pixel = proc_pix;
        n_s1.emit     = emit;
        n_s1.border   = border;
        n_s1.last     = last;
        n_s1.row      = r_res_row;
        n_s1.col      = r_res_col;
        n_s1.addr     = c_addr;
        n_s1.pixel    = i_in.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_done <= 1'b0;
            r_pending <= '0;
            r_res_row <= '0;
            r_res_col <= '0;
        end else if (in_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_done <= n_in_done;
            r_pending <= n_pending;
            r_res_row <= n_res_row;
            r_res_col <= n_res_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (in_acc) begin
            r_s1 <= n_s1;
        end else if (s1_adv) begin
            r_s1.valid <= 1'b0;
        end
    end

    // Line buffers. The same entry is read again at least two requests later,
    // by which time the write-back of the earlier request has landed.
    always_ff @(posedge i_clk) begin
        if (in_acc && proc_pix) begin
            r_top <= r_older_mem[c_addr];
            r_mid <= r_newer_mem[c_addr];
        end
        if (s1_adv && r_s1.is_pixel) begin
            r_older_mem[r_s1.addr] <= r_mid;
            r_newer_mem[r_s1.addr] <= r_s1.pixel;
        end
    end

    // The window is centered one row and one column behind the incoming pixel.
    always_comb begin
        gv = t_grad'(r_recent2) - t_grad'(r_above_prev);
        gh = t_grad'(r_mid) - t_grad'(r_recent1);
        if (!r_s1.is_pixel || r_s1.border) begin
            gv = '0;
            gh = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr || (s1_adv && r_s1.last)) begin
            r_recent0    <= '0;
            r_recent1    <= '0;
            r_recent2    <= '0;
            r_above_prev <= '0;
        end else if (s1_adv && r_s1.is_pixel) begin
            r_recent1    <= r_recent0;
            r_recent0    <= r_mid;
            r_recent2    <= r_s1.pixel;
            r_above_prev <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_out_gv   <= gv;
            r_out_gh   <= gh;
            r_out_row  <= r_s1.row;
            r_out_col  <= r_s1.col;
            r_out_last <= r_s1.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.grad_vert  = r_out_gv;
    assign o_out.grad_horiz = r_out_gh;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.frame_end  = r_out_last;

`ifndef ASSERT_OFF
    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1.valid)
        else $error("input stalled with the RAM stage empty");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pending} <= {1'b0, r_width_eff} + 1'b1)
        else $error("pending result count above image_width+1");

    a_no_output_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_load && r_out_valid) |-> o_out.ready)
        else $error("result register overwritten before it was taken");

    a_done_at_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_done |-> (r_in_col == '0))
        else $error("input complete in the middle of a row");
`endif

endmodule
